@@ sv/circular_deque_core_macros.svh @@
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shared property wrappers for the deque core checks.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CDQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// Circular deque package
// Request codes, word types and controller types shared by the deque core.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned CAP_W     = 11;
  localparam int unsigned CAP_RESET = 1024;
  localparam int unsigned DATA_W    = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_STATUS     = 3'd4;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] item_value;
  } req_word_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } rsp_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic read;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences each request through update, store read and response.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  output cdq_pkg::cmd_t      cmd
);

  cdq_pkg::state_t state;
  cdq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    cmd        = '0;
    unique case (state)
      cdq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cdq_pkg::ST_EXEC;
        end
      end
      cdq_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = cdq_pkg::ST_READ;
      end
      cdq_pkg::ST_READ: begin
        busy       = 1'b1;
        cmd.read   = 1'b1;
        state_next = cdq_pkg::ST_RESP;
      end
      cdq_pkg::ST_RESP: begin
        // The response word is registered, so a new request may enter now.
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cdq_pkg::ST_EXEC;
        end else begin
          state_next = cdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/cdq_dp.sv @@
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring store, head and tail pointers, entry count and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cdq_pkg::cmd_t             cmd,
  input  wire cdq_pkg::req_word_t        req,
  input  wire logic                      cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_wdata,
  output cdq_pkg::rsp_word_t             result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned CAP_RST =
    (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  cdq_pkg::req_word_t req_q;
  logic [CW-1:0]      cap;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      count;
  logic               ok;

  logic [AW-1:0]      head_next;
  logic [AW-1:0]      tail_next;
  logic [CW-1:0]      count_next;
  logic               ok_next;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  logic [CW-1:0]      cap_cfg;
  logic [31:0]        cfg_wide;
  logic [AW-1:0]      cap_m1;
  logic [CW-1:0]      head_inc;
  logic [CW-1:0]      tail_inc;
  logic               has_room;
  logic               has_item;

  logic [cdq_pkg::DATA_W-1:0] rd_front;
  logic [cdq_pkg::DATA_W-1:0] rd_rear;
  logic                       empty_q;
  logic                       full_q;

  // Capacity outside 1..DEPTH is clamped when the register is written.
  always_comb begin
    cfg_wide = 32'(cfg_wdata);
    if (cfg_wide == 32'd0) begin
      cap_cfg = CW'(1);
    end else if (cfg_wide > 32'(DEPTH)) begin
      cap_cfg = CW'(DEPTH);
    end else begin
      cap_cfg = CW'(cfg_wide);
    end
  end

  always_comb begin
    cap_m1     = AW'(cap - CW'(1));
    head_inc   = CW'(head) + CW'(1);
    tail_inc   = CW'(tail) + CW'(1);
    has_room   = (count < cap);
    has_item   = (count != '0);
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok_next    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    case (req_q.req_type)
      cdq_pkg::REQ_PUSH_FRONT: begin
        if (has_room) begin
          head_next  = (head_inc >= cap) ? '0 : AW'(head_inc);
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + CW'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::REQ_PUSH_REAR: begin
        if (has_room) begin
          tail_next  = (tail == '0) ? cap_m1 : tail - AW'(1);
          wr_en      = 1'b1;
          wr_addr    = tail_next;
          count_next = count + CW'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::REQ_POP_FRONT: begin
        if (has_item) begin
          head_next  = (head == '0) ? cap_m1 : head - AW'(1);
          count_next = count - CW'(1);
          ok_next    = 1'b1;
        end
      end
      cdq_pkg::REQ_POP_REAR: begin
        if (has_item) begin
          tail_next  = (tail_inc >= cap) ? '0 : AW'(tail_inc);
          count_next = count - CW'(1);
          ok_next    = 1'b1;
        end
      end
      default: begin
        // Status requests and unused codes leave the deque unchanged.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CW'(CAP_RST);
      head  <= AW'(CAP_RST - 1);
      tail  <= '0;
      count <= '0;
    end else if (cfg_we) begin
      cap   <= cap_cfg;
      head  <= AW'(cap_cfg - CW'(1));
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      ok <= ok_next;
    end
    if (cmd.read) begin
      empty_q <= (count == '0);
      full_q  <= (count >= cap);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= req_q.item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front <= mem[head];
      rd_rear  <= mem[tail];
    end
  end

  always_comb begin
    result.accepted    = ok;
    result.is_empty    = empty_q;
    result.is_full     = full_q;
    result.front_value = empty_q ? '1 : rd_front;
    result.rear_value  = empty_q ? '1 : rd_rear;
  end

endmodule

`default_nettype wire

@@ sv/circular_deque_core.sv @@
// ----------------------------------------------------------------------------
// Circular deque core
// Double-ended queue of 32-bit words held in a ring store of DEPTH entries.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Its response
// word appears on result with done high for exactly one cycle; the receiver
// cannot stall it, so it must capture result whenever done is high. A new
// request may be presented in the cycle done is high. Each request first moves
// the pointers and writes the store, then does the registered two-port store
// read of front and rear, then presents the response. Writing capacity empties
// the deque; the user must write it only while no request is in flight, as the
// block itself does not enforce this.
`default_nettype none

module circular_deque_core #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire cdq_pkg::req_word_t        req,
  output logic                           done,
  output cdq_pkg::rsp_word_t             result,
  input  wire logic                      cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_wdata
);

  cdq_pkg::cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

`include "circular_deque_core_macros.svh"

  `CDQ_ASSERT_IMPLY(a_not_empty_and_full, clk, rst, done, !(result.is_empty && result.is_full), "deque reported empty and full at once")
  `CDQ_ASSERT_IMPLY(a_empty_reads_ones, clk, rst, done && result.is_empty, (result.front_value == '1) && (result.rear_value == '1), "empty deque returned a stored word")
  `CDQ_ASSERT_NEXT(a_taken_goes_busy, clk, rst, start && !busy, busy && !done, "request word taken without starting work")
  `CDQ_ASSERT_IMPLY(a_done_after_busy, clk, rst, done, $past(busy) && !busy, "response word without a request in flight")

endmodule

`default_nettype wire

@@ tb/sv/tb_circular_deque_core.sv @@
// ----------------------------------------------------------------------------
// Circular deque core testbench
// Drives push, pop, status and unused-code request words through the core and
// checks every response word against a behavioral deque kept in the testbench,
// across a series of capacity settings that includes the clamped extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_deque_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned IDLE_PCT   = 14;
  localparam int unsigned CALM_FIRST = 400;
  localparam int unsigned CALM_LAST  = 800;

  localparam logic [2:0] REQ_UNKNOWN_LO  = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_MID = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_HI  = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  cdq_pkg::req_word_t            req_word = '0;
  logic                          done;
  cdq_pkg::rsp_word_t            rsp_word;
  logic                          cfg_we = 1'b0;
  logic [cdq_pkg::CAP_W-1:0]     cfg_wdata = '0;

  cdq_pkg::req_word_t            pending_req[$];
  cdq_pkg::rsp_word_t            expected_rsp[$];
  int unsigned                   words_taken = 0;
  int unsigned                   mismatches = 0;
  int unsigned                   stall_cycles = 0;

  // Shadow deque.
  logic [cdq_pkg::DATA_W-1:0]    shadow_mem [0:DEPTH-1];
  int unsigned                   front_idx;
  int unsigned                   rear_idx;
  int unsigned                   fill_level;
  int unsigned                   cap_eff;

  circular_deque_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req_word),
    .done     (done),
    .result   (rsp_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A capacity write clamps to 1..DEPTH and empties the deque.
  function automatic void set_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
    if (cap == '0) begin
      cap_eff = 1;
    end else if (cap > DEPTH) begin
      cap_eff = DEPTH;
    end else begin
      cap_eff = 32'(cap);
    end
    front_idx  = cap_eff - 1;
    rear_idx   = 0;
    fill_level = 0;
  endfunction

  function automatic cdq_pkg::rsp_word_t deque_apply(input cdq_pkg::req_word_t w);
    cdq_pkg::rsp_word_t r;
    r = '0;
    case (w.req_type)
      cdq_pkg::REQ_PUSH_FRONT: begin
        if (fill_level < cap_eff) begin
          front_idx = (front_idx + 1 >= cap_eff) ? 0 : front_idx + 1;
          shadow_mem[front_idx] = w.item_value;
          fill_level++;
          r.accepted = 1'b1;
        end
      end
      cdq_pkg::REQ_PUSH_REAR: begin
        if (fill_level < cap_eff) begin
          rear_idx = (rear_idx == 0) ? cap_eff - 1 : rear_idx - 1;
          shadow_mem[rear_idx] = w.item_value;
          fill_level++;
          r.accepted = 1'b1;
        end
      end
      cdq_pkg::REQ_POP_FRONT: begin
        if (fill_level > 0) begin
          front_idx = (front_idx == 0) ? cap_eff - 1 : front_idx - 1;
          fill_level--;
          r.accepted = 1'b1;
        end
      end
      cdq_pkg::REQ_POP_REAR: begin
        if (fill_level > 0) begin
          rear_idx = (rear_idx + 1 >= cap_eff) ? 0 : rear_idx + 1;
          fill_level--;
          r.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.front_value = (fill_level > 0) ? shadow_mem[front_idx] : '1;
    r.rear_value  = (fill_level > 0) ? shadow_mem[rear_idx] : '1;
    r.is_empty    = (fill_level == 0);
    r.is_full     = (fill_level >= cap_eff);
    return r;
  endfunction

  function automatic cdq_pkg::req_word_t mk_word(input logic [2:0] kind,
                                                 input logic [31:0] value);
    cdq_pkg::req_word_t w;
    w.req_type   = kind;
    w.item_value = value;
    return w;
  endfunction

  // push_pct steers the fill level: high values drive toward full, low toward empty.
  function automatic cdq_pkg::req_word_t random_word(input int unsigned push_pct);
    int unsigned roll;
    int unsigned pick;
    logic [2:0]  kind;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < push_pct) begin
      kind = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_REAR : cdq_pkg::REQ_PUSH_FRONT;
    end else if (roll < 96) begin
      kind = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_REAR : cdq_pkg::REQ_POP_FRONT;
    end else if (roll < 98) begin
      kind = cdq_pkg::REQ_STATUS;
    end else begin
      kind = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end
    case (pick)
      0: value = 32'h7fff_ffff;
      1: value = 32'h8000_0000;
      2: value = 32'h0000_0000;
      3: value = 32'hffff_ffff;
      default: value = $urandom;
    endcase
    return mk_word(kind, value);
  endfunction

  // Request driver: holds a word while busy, otherwise idles now and then.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rsp.push_back(deque_apply(req_word));
        void'(pending_req.pop_front());
        words_taken++;
      end
      if (!(start && busy)) begin
        if (pending_req.size() > 0 &&
            ((words_taken >= CALM_FIRST && words_taken < CALM_LAST) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          start    <= 1'b1;
          req_word <= pending_req[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Response monitor and watchdog.
  always @(posedge clk) begin
    cdq_pkg::rsp_word_t exp_w;
    if (!rst) begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          $error("unexpected response word: %h", rsp_word);
          mismatches++;
        end else begin
          exp_w = expected_rsp.pop_front();
          check_field("accepted", 32'(exp_w.accepted), 32'(rsp_word.accepted));
          check_field("front_value", exp_w.front_value, rsp_word.front_value);
          check_field("rear_value", exp_w.rear_value, rsp_word.rear_value);
          check_field("is_empty", 32'(exp_w.is_empty), 32'(rsp_word.is_empty));
          check_field("is_full", 32'(exp_w.is_full), 32'(rsp_word.is_full));
        end
      end
      if ((start && !busy) || done) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_req.size() > 0 || start || expected_rsp.size() > 0) begin
      @(negedge clk);
    end
  endtask

  // Waits until the core is idle before writing; the extra cycles cover the pipeline.
  task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    set_capacity(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [cdq_pkg::CAP_W-1:0] caps [10];
    int unsigned               n_words;
    int unsigned               pct;
    caps = '{11'd2, 11'd3, 11'd2047, 11'd5, 11'd1, 11'd16, 11'd1024, 11'd7, 11'd0, 11'd64};
    set_capacity(cdq_pkg::CAP_W'(cdq_pkg::CAP_RESET));
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset capacity: refused pops on empty, extreme values at both ends.
    pending_req.push_back(mk_word(cdq_pkg::REQ_STATUS, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_REAR, 32'h0));
    pending_req.push_back(mk_word(REQ_UNKNOWN_LO, 32'hdead_beef));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_REAR, 32'h8000_0000));
    pending_req.push_back(mk_word(cdq_pkg::REQ_STATUS, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_REAR, 32'hffff_ffff));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_REAR, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_REAR, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));
    pending_req.push_back(mk_word(REQ_UNKNOWN_MID, 32'h0));
    pending_req.push_back(mk_word(REQ_UNKNOWN_HI, 32'h0));

    // Single entry: a second push is refused while full.
    write_capacity(11'd1);
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_REAR, 32'h1234_5678));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_FRONT, 32'h5555_5555));
    pending_req.push_back(mk_word(cdq_pkg::REQ_STATUS, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_REAR, 32'h0));

    // Zero capacity acts as one.
    write_capacity(11'd0);
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_FRONT, 32'haaaa_aaaa));
    pending_req.push_back(mk_word(cdq_pkg::REQ_PUSH_REAR, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));
    pending_req.push_back(mk_word(cdq_pkg::REQ_POP_FRONT, 32'h0));

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      // The oversized capacity clamps to DEPTH and gets one long fill and drain.
      n_words = (caps[p] > DEPTH) ? 1150 : 50;
      for (int unsigned i = 0; i < n_words; i++) begin
        if (caps[p] > DEPTH) begin
          pct = (i < 1060) ? 92 : 8;
        end else begin
          pct = ((i / 12) % 2) ? 75 : 25;
        end
        pending_req.push_back(random_word(pct));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
